// ----- rtl/life_pkg.sv -----
// Shared types and constants for the life automaton generation block.
`timescale 1ns / 1ps
`default_nettype none

package life_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned COUNT_W = 4;

  localparam logic [COUNT_W-1:0] LIFE_SURVIVE_LOW  = 4'd2;
  localparam logic [COUNT_W-1:0] LIFE_SURVIVE_HIGH = 4'd3;
  localparam logic [COUNT_W-1:0] LIFE_BIRTH        = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_STEP   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_SET    = 2'd2,
    OP_READ   = 2'd3
  } life_op_t;

  typedef struct packed {
    logic latch;
    logic clr_wr;
    logic rd_row;
    logic rd_edit;
    logic step_first;
    logic step_run;
    logic edit_wr;
    logic load_out;
  } life_cmd_t;

  typedef struct packed {
    life_op_t op;
    logic     in_grid;
    logic     clr_last;
    logic     step_last;
  } life_status_t;

endpackage

`default_nettype wire

// ----- rtl/life_dp.sv -----
// Datapath: row memory, three-row window, next-generation logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module life_dp #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  life_pkg::life_op_t                in_op,
  input  wire [life_pkg::COORD_W-1:0]       in_col,
  input  wire [life_pkg::COORD_W-1:0]       in_row,
  input  life_pkg::life_cmd_t               cmd,
  output life_pkg::life_status_t            status,
  output logic                              cell_alive
);
  import life_pkg::*;

  localparam int unsigned RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned RPW = $clog2(GRID_ROWS + 1);
  localparam int unsigned CW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  logic [GRID_COLS-1:0] mem [GRID_ROWS];

  life_op_t             cmd_op;
  logic [COORD_W-1:0]   cmd_col;
  logic [COORD_W-1:0]   cmd_row;
  logic [GRID_COLS-1:0] rdata;
  logic [GRID_COLS-1:0] prev_row;
  logic [GRID_COLS-1:0] cur_row;
  logic [RW-1:0]        wptr;
  logic [RPW-1:0]       rptr;

  logic                 in_grid;
  logic [RW-1:0]        row_addr;
  logic [CW-1:0]        col_addr;
  logic [GRID_COLS-1:0] nxt_row;
  logic [GRID_COLS-1:0] new_row;
  logic [GRID_COLS-1:0] edit_row;
  logic [GRID_COLS+1:0] pad_prev;
  logic [GRID_COLS+1:0] pad_cur;
  logic [GRID_COLS+1:0] pad_nxt;

  assign in_grid  = (cmd_col < GRID_COLS) && (cmd_row < GRID_ROWS);
  assign row_addr = RW'(cmd_row);
  assign col_addr = CW'(cmd_col);

  assign status.op        = cmd_op;
  assign status.in_grid   = in_grid;
  assign status.clr_last  = (wptr == RW'(GRID_ROWS - 1));
  assign status.step_last = (wptr == RW'(GRID_ROWS - 1));

  assign nxt_row  = status.step_last ? '0 : rdata;
  assign pad_prev = {1'b0, prev_row, 1'b0};
  assign pad_cur  = {1'b0, cur_row, 1'b0};
  assign pad_nxt  = {1'b0, nxt_row, 1'b0};

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    logic [COUNT_W-1:0] n;
    assign n = COUNT_W'(pad_prev[c]) + COUNT_W'(pad_prev[c+1]) + COUNT_W'(pad_prev[c+2])
             + COUNT_W'(pad_cur[c])                            + COUNT_W'(pad_cur[c+2])
             + COUNT_W'(pad_nxt[c])  + COUNT_W'(pad_nxt[c+1])  + COUNT_W'(pad_nxt[c+2]);
    assign new_row[c] = cur_row[c] ? (n >= LIFE_SURVIVE_LOW && n <= LIFE_SURVIVE_HIGH)
                                   : (n == LIFE_BIRTH);
  end

  always_comb begin
    edit_row = rdata;
    if (cmd_op == OP_TOGGLE) begin
      edit_row[col_addr] = ~rdata[col_addr];
    end else begin
      edit_row[col_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_op  <= in_op;
      cmd_col <= in_col;
      cmd_row <= in_row;
    end
    if (cmd.rd_row && (rptr < GRID_ROWS)) begin
      rdata <= mem[rptr[RW-1:0]];
    end else if (cmd.rd_edit && in_grid) begin
      rdata <= mem[row_addr];
    end
    if (cmd.step_first) begin
      prev_row <= '0;
      cur_row  <= rdata;
    end else if (cmd.step_run) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
    if (cmd.load_out) begin
      cell_alive <= (cmd_op == OP_READ) && in_grid && rdata[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[wptr] <= '0;
    end else if (cmd.step_run) begin
      mem[wptr] <= new_row;
    end else if (cmd.edit_wr) begin
      mem[row_addr] <= edit_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (cmd.latch) begin
        wptr <= '0;
      end else if (cmd.clr_wr || cmd.step_run) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd.latch) begin
        rptr <= '0;
      end else if (cmd.rd_row) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/life_ctrl.sv -----
// Controller: sequences clearing, generation sweeps, cell edits and the result handshake.
`timescale 1ns / 1ps
`default_nettype none

module life_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  input  life_pkg::life_status_t  status,
  output life_pkg::life_cmd_t     cmd
);
  import life_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_STEP_FIRST,
    S_STEP_RUN,
    S_EDIT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.op == OP_STEP) begin
          cmd.rd_row = 1'b1;
          state_next = S_STEP_FIRST;
        end else begin
          cmd.rd_edit = 1'b1;
          state_next  = S_EDIT;
        end
      end
      S_STEP_FIRST: begin
        cmd.step_first = 1'b1;
        cmd.rd_row     = 1'b1;
        state_next     = S_STEP_RUN;
      end
      S_STEP_RUN: begin
        cmd.step_run = 1'b1;
        cmd.rd_row   = 1'b1;
        if (status.step_last) begin
          state_next = S_FINISH;
        end
      end
      S_EDIT: begin
        cmd.edit_wr = status.in_grid && (status.op == OP_TOGGLE || status.op == OP_SET);
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/life_automaton_generation.sv -----
// Top level of the B3/S23 life automaton: one command per item, one result per item.
// Step: one row per cycle through the single-read, single-write row memory with a three-row window.
// Toggle and set: read-modify-write of one row; read: read of one row.
// Items are taken one at a time; a waiting result does not block the next accept.
// Reset: synchronous; a clearing pass zeroes every row of the grid, no item taken.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_generation #(
  parameter int unsigned GRID_COLS = 64,
  parameter int unsigned GRID_ROWS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,  // opcode[1:0], col[7:2], row[13:8], zero[15:14]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata   // cell_alive[0], zero[7:1]
);
  import life_pkg::*;

  life_cmd_t    cmd;
  life_status_t status;
  logic         cell_alive;

  life_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  life_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (life_op_t'(s_tdata[1:0])),
    .in_col     (s_tdata[7:2]),
    .in_row     (s_tdata[13:8]),
    .cmd        (cmd),
    .status     (status),
    .cell_alive (cell_alive)
  );

  assign m_tdata = {7'b0, cell_alive};

endmodule

`default_nettype wire

// ----- sim/life_checker.sv -----
// Checker for the life automaton: predicts each result from the accepted commands and compares.
`timescale 1ns / 1ps

module life_checker #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [15:0] s_tdata,   // opcode[1:0], col[7:2], row[13:8], zero[15:14]
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [7:0]  m_tdata,   // cell_alive[0], zero[7:1]
  output int         fail_count,
  output int         pending
);
  import life_pkg::*;

  typedef struct {
    int unsigned seq;
    life_op_t    op;
    bit          alive;
  } alive_due_t;

  bit [GRID_COLS-1:0] life_grid [GRID_ROWS];
  alive_due_t         alive_due [$];
  int unsigned        cmd_seq;
  int unsigned        result_seq;

  task automatic report_mismatch(string what, int unsigned seq, int got, int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", seq, what, got, want);
    fail_count++;
  endtask

  function automatic int live_neighbours(int r, int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_ROWS &&
            c + dc >= 0 && c + dc < GRID_COLS) begin
          if (life_grid[r + dr][c + dc]) n++;
        end
      end
    end
    return n;
  endfunction

  function automatic void evolve_grid();
    bit [GRID_COLS-1:0] next_gen [GRID_ROWS];
    int n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        n = live_neighbours(r, c);
        if (life_grid[r][c])
          next_gen[r][c] = (n >= int'(LIFE_SURVIVE_LOW)) && (n <= int'(LIFE_SURVIVE_HIGH));
        else
          next_gen[r][c] = (n == int'(LIFE_BIRTH));
      end
    end
    life_grid = next_gen;
  endfunction

  function automatic bit apply_command(life_op_t op, int row, int col);
    bit in_grid;
    bit alive;
    in_grid = (col < GRID_COLS) && (row < GRID_ROWS);
    alive = 1'b0;
    case (op)
      OP_STEP: begin
        evolve_grid();
      end
      OP_TOGGLE: begin
        if (in_grid) life_grid[row][col] = ~life_grid[row][col];
      end
      OP_SET: begin
        if (in_grid) life_grid[row][col] = 1'b1;
      end
      default: begin
        if (in_grid) alive = life_grid[row][col];
      end
    endcase
    return alive;
  endfunction

  always @(posedge clk) begin
    alive_due_t due;
    life_op_t   op;
    if (rst) begin
      foreach (life_grid[r]) life_grid[r] = '0;
      alive_due.delete();
      fail_count = 0;
      cmd_seq    = 0;
      result_seq = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (alive_due.size() == 0) begin
          report_mismatch("item with no command waiting", result_seq, m_tdata[0], 0);
        end else begin
          due = alive_due.pop_front();
          if (m_tdata[0] !== due.alive)
            report_mismatch($sformatf("cell_alive (%s, command %0d)", due.op.name(), due.seq),
                            result_seq, m_tdata[0], due.alive);
          if (m_tdata[7:1] !== 7'd0)
            report_mismatch("padding", result_seq, m_tdata[7:1], 0);
        end
        result_seq++;
      end
      if (s_tvalid && s_tready) begin
        op = life_op_t'(s_tdata[1:0]);
        due.seq   = cmd_seq;
        due.op    = op;
        due.alive = apply_command(op, int'(s_tdata[13:8]), int'(s_tdata[7:2]));
        alive_due.push_back(due);
        cmd_seq++;
      end
    end
    pending = alive_due.size();
  end

endmodule

// ----- sim/tb_life_automaton_generation.sv -----
// Testbench top for the life automaton: drives commands and result backpressure, gives the verdict.
`timescale 1ns / 1ps

module tb_life_automaton_generation;
  import life_pkg::*;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int RANDOM_CMDS = 750;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // opcode[1:0], col[7:2], row[13:8], zero[15:14]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // cell_alive[0], zero[7:1]

  int fail_count;
  int pending;
  int cycle_count = 0;
  int tx_calm_left = 0;
  bit tx_calm = 1'b0;
  int rx_wait = 0;
  int rx_calm_left = 0;
  bit rx_calm = 1'b0;

  life_automaton_generation #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  life_checker #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("life_automaton_generation test failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles after each item, with calm stretches.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tready && m_tvalid) begin
      if (rx_calm_left == 0) begin
        rx_calm      = ($urandom_range(0, 2) == 0);
        rx_calm_left = $urandom_range(10, 40);
      end
      rx_calm_left--;
      w = rx_calm ? 0 : $urandom_range(0, 17);
      if (w != 0) begin
        m_tready <= 1'b0;
        rx_wait  <= w;
      end
    end else if (!m_tready) begin
      if (rx_wait <= 1) m_tready <= 1'b1;
      rx_wait <= rx_wait - 1;
    end
  end

  task automatic send_cmd(life_op_t op, int row, int col);
    int gap;
    if (tx_calm_left == 0) begin
      tx_calm      = ($urandom_range(0, 2) == 0);
      tx_calm_left = $urandom_range(10, 40);
    end
    tx_calm_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, row[5:0], col[5:0], op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  function automatic life_op_t any_op();
    return life_op_t'($urandom_range(0, 3));
  endfunction

  initial begin
    int sent;
    int span;
    int r0;
    int c0;
    int edits;
    int steps;
    int reads;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Corner block, lone corner cell, bottom-edge blinker, double toggle.
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_SET, 0, 0);
    send_cmd(OP_SET, 0, 1);
    send_cmd(OP_SET, 1, 0);
    send_cmd(OP_SET, 1, 1);
    send_cmd(OP_SET, 63, 63);
    send_cmd(OP_SET, 63, 30);
    send_cmd(OP_SET, 63, 31);
    send_cmd(OP_TOGGLE, 63, 32);
    send_cmd(OP_TOGGLE, 5, 5);
    send_cmd(OP_TOGGLE, 5, 5);
    send_cmd(OP_SET, 0, 63);
    send_cmd(OP_STEP, 63, 63);
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_READ, 1, 1);
    send_cmd(OP_READ, 63, 63);
    send_cmd(OP_READ, 62, 31);
    send_cmd(OP_READ, 63, 31);
    send_cmd(OP_READ, 63, 30);
    send_cmd(OP_READ, 0, 63);
    send_cmd(OP_READ, 5, 5);
    send_cmd(OP_STEP, 0, 0);
    send_cmd(OP_READ, 63, 31);
    send_cmd(OP_READ, 62, 31);

    // Seed a window with a pattern, evolve it and probe around it; add some noise.
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      span = $urandom_range(3, 10);
      case ($urandom_range(0, 3))
        0: r0 = 0;
        1: r0 = 64 - span;
        default: r0 = $urandom_range(0, 64 - span);
      endcase
      case ($urandom_range(0, 3))
        0: c0 = 0;
        1: c0 = 64 - span;
        default: c0 = $urandom_range(0, 64 - span);
      endcase
      edits = $urandom_range(4, 20);
      for (int i = 0; i < edits; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_cmd(any_op(), $urandom_range(0, 63), $urandom_range(0, 63));
        else
          send_cmd(($urandom_range(0, 2) == 0) ? OP_TOGGLE : OP_SET,
                   r0 + $urandom_range(0, span - 1), c0 + $urandom_range(0, span - 1));
        sent++;
      end
      steps = $urandom_range(1, 4);
      for (int s = 0; s < steps; s++) begin
        send_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
        sent++;
        reads = $urandom_range(1, 6);
        for (int i = 0; i < reads; i++) begin
          send_cmd(OP_READ, clamp_coord(r0 - 1 + $urandom_range(0, span + 1)),
                   clamp_coord(c0 - 1 + $urandom_range(0, span + 1)));
          sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("life_automaton_generation test passed");
    end else begin
      $display("life_automaton_generation test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/life_pkg.sv
rtl/life_dp.sv
rtl/life_ctrl.sv
rtl/life_automaton_generation.sv
sim/life_checker.sv
sim/tb_life_automaton_generation.sv
